>>> src/adlm_pkg.sv
package adlm_pkg;

  // Field widths
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned MAG_W    = ANGLE_W + 1;
  localparam int unsigned TRIG_SQ_W = 2 * THR_W;
  localparam int unsigned RATE_SQ_W = 32;

  // Configuration bus
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TILT_TRIGGER   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TILT_CLEAR     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE_TRIGGER   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VIOL_TIME_NEED = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_QUIET_TIME_NEED = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP_TIME  = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0]  TILT_TRIGGER_RST   = 15'd1430;
  localparam logic [THR_W-1:0]  TILT_CLEAR_RST     = 15'd715;
  localparam logic [THR_W-1:0]  RATE_TRIGGER_RST   = 15'd8192;
  localparam logic [TIME_W-1:0] VIOL_TIME_NEED_RST = 32'd300000;
  localparam logic [TIME_W-1:0] QUIET_TIME_NEED_RST = 32'd500000;
  localparam logic [STEP_W-1:0] MAX_STEP_TIME_RST  = 20'd100000;
  localparam logic [TRIG_SQ_W-1:0] RATE_TRIG_SQ_RST =
    TRIG_SQ_W'(RATE_TRIGGER_RST) * TRIG_SQ_W'(RATE_TRIGGER_RST);

  // Bounds of the landing phase range that authorizes monitoring
  localparam logic [PHASE_W-1:0] PHASE_FINAL_DESCENT = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_TOUCHDOWN_HOLD = 3'd3;

  // Reason codes
  typedef enum logic [REASON_W-1:0] {
    RSN_UNAUTHORIZED = 3'd0,
    RSN_INVALID      = 3'd1,
    RSN_SUSTAINED_RATE = 3'd2,
    RSN_SUSTAINED_TILT = 3'd3,
    RSN_TRANSIENT    = 3'd4,
    RSN_SAFE         = 3'd5
  } reason_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [THR_W-1:0]     tilt_trigger;
    logic [THR_W-1:0]     tilt_clear;
    logic [TRIG_SQ_W-1:0] rate_trig_sq;
    logic [TIME_W-1:0]    viol_time_need;
    logic [TIME_W-1:0]    quiet_time_need;
    logic [STEP_W-1:0]    max_step_time;
  } adlm_cfg_t;

  // One captured input sample
  typedef struct packed {
    logic                      enable;
    logic [PHASE_W-1:0]        landing_phase;
    logic                      sample_valid;
    logic [STEP_W-1:0]         step_time;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] rate_x;
    logic signed [ANGLE_W-1:0] rate_y;
  } adlm_item_t;

  // Magnitude of a two's complement Q2.13 value (0x8000 gives 32768)
  function automatic logic [MAG_W-1:0] mag16(input logic [ANGLE_W-1:0] raw);
    logic [MAG_W-1:0] ext;
    ext = {1'b0, raw};
    if (raw[ANGLE_W-1]) begin
      return (MAG_W'(1) << ANGLE_W) - ext;
    end
    return ext;
  endfunction

  // Saturating 32-bit accumulate of a step time
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] acc,
                                                input logic [STEP_W-1:0] step);
    logic [TIME_W:0] sum;
    sum = {1'b0, acc} + (TIME_W + 1)'(step);
    if (sum[TIME_W]) begin
      return '1;
    end
    return sum[TIME_W-1:0];
  endfunction

endpackage

>>> src/adlm_if.sv
interface adlm_in_if;
  import adlm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      enable;
  logic [PHASE_W-1:0]        landing_phase;
  logic                      sample_valid;
  logic [STEP_W-1:0]         step_time;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] rate_x;
  logic signed [ANGLE_W-1:0] rate_y;

  modport source (
    output valid, enable, landing_phase, sample_valid, step_time,
           roll_angle, pitch_angle, rate_x, rate_y,
    input  ready
  );

  modport sink (
    input  valid, enable, landing_phase, sample_valid, step_time,
           roll_angle, pitch_angle, rate_x, rate_y,
    output ready
  );
endinterface

interface adlm_out_if;
  import adlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  sample_accepted;
  logic                  warning_now;
  logic                  recovery_request;
  logic [TIME_W-1:0]     violation_time;
  logic [ANGLE_W-1:0]    tilt_error;
  logic [REASON_W-1:0]   reason_code;

  modport source (
    output valid, sample_accepted, warning_now, recovery_request,
           violation_time, tilt_error, reason_code,
    input  ready
  );

  modport sink (
    input  valid, sample_accepted, warning_now, recovery_request,
           violation_time, tilt_error, reason_code,
    output ready
  );
endinterface

>>> src/adlm_regs.sv
module adlm_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adlm_pkg::PADDR_W-1:0]  paddr,
  input  logic [adlm_pkg::PDATA_W-1:0]  pwdata,
  output logic [adlm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output adlm_pkg::adlm_cfg_t           cfg
);
  import adlm_pkg::*;

  logic [THR_W-1:0]     tilt_trigger_r;
  logic [THR_W-1:0]     tilt_clear_r;
  logic [THR_W-1:0]     rate_trigger_r;
  logic [TIME_W-1:0]    viol_time_need_r;
  logic [TIME_W-1:0]    quiet_time_need_r;
  logic [STEP_W-1:0]    max_step_time_r;
  logic [TRIG_SQ_W-1:0] rate_trig_sq_r;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes; the squared rate trigger is loaded together with rate_trigger_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_trigger_r    <= TILT_TRIGGER_RST;
      tilt_clear_r      <= TILT_CLEAR_RST;
      rate_trigger_r    <= RATE_TRIGGER_RST;
      rate_trig_sq_r    <= RATE_TRIG_SQ_RST;
      viol_time_need_r  <= VIOL_TIME_NEED_RST;
      quiet_time_need_r <= QUIET_TIME_NEED_RST;
      max_step_time_r   <= MAX_STEP_TIME_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TILT_TRIGGER:    tilt_trigger_r    <= pwdata[THR_W-1:0];
        REG_TILT_CLEAR:      tilt_clear_r      <= pwdata[THR_W-1:0];
        REG_RATE_TRIGGER: begin
          rate_trigger_r <= pwdata[THR_W-1:0];
          rate_trig_sq_r <= TRIG_SQ_W'(pwdata[THR_W-1:0]) * TRIG_SQ_W'(pwdata[THR_W-1:0]);
        end
        REG_VIOL_TIME_NEED:  viol_time_need_r  <= pwdata[TIME_W-1:0];
        REG_QUIET_TIME_NEED: quiet_time_need_r <= pwdata[TIME_W-1:0];
        REG_MAX_STEP_TIME:   max_step_time_r   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_TILT_TRIGGER:    prdata = PDATA_W'(tilt_trigger_r);
      REG_TILT_CLEAR:      prdata = PDATA_W'(tilt_clear_r);
      REG_RATE_TRIGGER:    prdata = PDATA_W'(rate_trigger_r);
      REG_VIOL_TIME_NEED:  prdata = PDATA_W'(viol_time_need_r);
      REG_QUIET_TIME_NEED: prdata = PDATA_W'(quiet_time_need_r);
      REG_MAX_STEP_TIME:   prdata = PDATA_W'(max_step_time_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.tilt_trigger    = tilt_trigger_r;
  assign cfg.tilt_clear      = tilt_clear_r;
  assign cfg.rate_trig_sq    = rate_trig_sq_r;
  assign cfg.viol_time_need  = viol_time_need_r;
  assign cfg.quiet_time_need = quiet_time_need_r;
  assign cfg.max_step_time   = max_step_time_r;

endmodule

>>> src/attitude_divergence_latch_monitor_core.sv
// Channel  Dir  Handshake             Payload
// in_ch    in   valid/ready           enable, phase, valid flag, step, roll, pitch, rates
// out_ch   out  valid/ready           accepted, warning, request, time, tilt, reason
// cfg      in   APB psel/penable      six registers at byte address 4*index
//
// One sample per cycle sustained while out_ch is ready; each sample passes from acceptance to result
// through the input register, then the evaluation and state update into the result register.
// Consecutive samples see each other's state updates without bubbles.
// Synchronous active-low reset clears the accumulators, the latch and both valid stages.
// A stalled result holds; the input register still takes one more transaction behind it.
module attitude_divergence_latch_monitor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  adlm_in_if.sink                       in_ch,
  adlm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adlm_pkg::PADDR_W-1:0]  paddr,
  input  logic [adlm_pkg::PDATA_W-1:0]  pwdata,
  output logic [adlm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import adlm_pkg::*;

  adlm_cfg_t  cfg;

  // Input stage
  logic       s1_valid_r;
  adlm_item_t item_r;
  logic       s1_move;
  logic       in_take;

  // Monitor state
  logic [TIME_W-1:0] viol_acc_r,  viol_acc_nxt;
  logic [TIME_W-1:0] quiet_acc_r, quiet_acc_nxt;
  logic              latch_r,     latch_nxt;

  // Result register
  logic               out_valid_r;
  logic               accepted_r,  accepted_nxt;
  logic               warning_r,   warning_nxt;
  logic               request_r,   request_nxt;
  logic [TIME_W-1:0]  vtime_r,     vtime_nxt;
  logic [ANGLE_W-1:0] tilt_err_r,  tilt_err_nxt;
  reason_t            reason_r,    reason_nxt;

  // Evaluation terms
  logic                 authorized;
  logic                 invalid;
  logic [MAG_W-1:0]     abs_roll, abs_pitch, tilt;
  logic [MAG_W-1:0]     abs_rx, abs_ry;
  logic [RATE_SQ_W-1:0] rx_sq, ry_sq, rate_sq;
  logic                 rate_hit;
  logic                 violation;
  logic [TIME_W-1:0]    viol_sum, quiet_sum;

  adlm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control
  assign s1_move     = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_move;
  assign in_take     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.enable        <= in_ch.enable;
      item_r.landing_phase <= in_ch.landing_phase;
      item_r.sample_valid  <= in_ch.sample_valid;
      item_r.step_time     <= in_ch.step_time;
      item_r.roll_angle    <= in_ch.roll_angle;
      item_r.pitch_angle   <= in_ch.pitch_angle;
      item_r.rate_x        <= in_ch.rate_x;
      item_r.rate_y        <= in_ch.rate_y;
    end
  end

  // Sample qualification
  assign authorized = item_r.enable &&
                      (item_r.landing_phase >= PHASE_FINAL_DESCENT) &&
                      (item_r.landing_phase <= PHASE_TOUCHDOWN_HOLD);
  assign invalid    = !item_r.sample_valid || (item_r.step_time == '0) ||
                      (item_r.step_time > cfg.max_step_time);

  // Tilt and rate triggers
  assign abs_roll  = mag16(item_r.roll_angle);
  assign abs_pitch = mag16(item_r.pitch_angle);
  assign tilt      = (abs_roll > abs_pitch) ? abs_roll : abs_pitch;
  assign abs_rx    = mag16(item_r.rate_x);
  assign abs_ry    = mag16(item_r.rate_y);
  assign rx_sq     = RATE_SQ_W'(abs_rx) * RATE_SQ_W'(abs_rx);
  assign ry_sq     = RATE_SQ_W'(abs_ry) * RATE_SQ_W'(abs_ry);
  assign rate_sq   = rx_sq + ry_sq;
  assign rate_hit  = rate_sq >= RATE_SQ_W'(cfg.rate_trig_sq);
  assign violation = (tilt >= MAG_W'(cfg.tilt_trigger)) || rate_hit;

  assign viol_sum  = sat_add(viol_acc_r, item_r.step_time);
  assign quiet_sum = sat_add(quiet_acc_r, item_r.step_time);

  // State update and result
  always_comb begin
    viol_acc_nxt  = viol_acc_r;
    quiet_acc_nxt = quiet_acc_r;
    latch_nxt     = latch_r;
    accepted_nxt  = 1'b0;
    warning_nxt   = 1'b0;
    request_nxt   = 1'b0;
    vtime_nxt     = viol_acc_r;
    tilt_err_nxt  = '0;
    reason_nxt    = RSN_UNAUTHORIZED;

    if (!authorized) begin
      viol_acc_nxt  = '0;
      quiet_acc_nxt = '0;
      latch_nxt     = 1'b0;
    end else if (invalid) begin
      request_nxt = latch_r;
      reason_nxt  = RSN_INVALID;
    end else begin
      if (violation) begin
        viol_acc_nxt  = viol_sum;
        quiet_acc_nxt = '0;
        if (viol_sum >= cfg.viol_time_need) begin
          latch_nxt = 1'b1;
        end
      end else if (tilt <= MAG_W'(cfg.tilt_clear)) begin
        quiet_acc_nxt = quiet_sum;
        if (!latch_r && (quiet_sum >= cfg.quiet_time_need)) begin
          viol_acc_nxt = '0;
        end
      end else begin
        quiet_acc_nxt = '0;
      end

      accepted_nxt = 1'b1;
      warning_nxt  = violation;
      request_nxt  = latch_nxt;
      vtime_nxt    = viol_acc_nxt;
      tilt_err_nxt = tilt[ANGLE_W-1:0];
      if (latch_nxt) begin
        reason_nxt = rate_hit ? RSN_SUSTAINED_RATE : RSN_SUSTAINED_TILT;
      end else begin
        reason_nxt = violation ? RSN_TRANSIENT : RSN_SAFE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viol_acc_r  <= '0;
      quiet_acc_r <= '0;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        viol_acc_r  <= viol_acc_nxt;
        quiet_acc_r <= quiet_acc_nxt;
        latch_r     <= latch_nxt;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      accepted_r <= accepted_nxt;
      warning_r  <= warning_nxt;
      request_r  <= request_nxt;
      vtime_r    <= vtime_nxt;
      tilt_err_r <= tilt_err_nxt;
      reason_r   <= reason_nxt;
    end
  end

  // Result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.sample_accepted  = accepted_r;
  assign out_ch.warning_now      = warning_r;
  assign out_ch.recovery_request = request_r;
  assign out_ch.violation_time   = vtime_r;
  assign out_ch.tilt_error       = tilt_err_r;
  assign out_ch.reason_code      = reason_r;

endmodule
